@@ sv/epws_pkg.sv @@
// ----------------------------------------------------------------------------
// epws_pkg
// Shared types, constants and address-split helpers of the page write splitter.
// ----------------------------------------------------------------------------
package epws_pkg;

  localparam int unsigned MAX_TRANSFER = 256;
  localparam int unsigned ADDR_W       = 17;
  localparam int unsigned LEN_W        = 9;
  localparam int unsigned CODE_W       = 4;
  localparam int unsigned QDEPTH       = 2;
  localparam int unsigned QPTR_W       = $clog2(QDEPTH);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_TRANSFER);

  // Device size codes: the part holds 2^code Kbit
  localparam logic [CODE_W-1:0] SZ_1K   = 4'd0;
  localparam logic [CODE_W-1:0] SZ_2K   = 4'd1;
  localparam logic [CODE_W-1:0] SZ_4K   = 4'd2;
  localparam logic [CODE_W-1:0] SZ_8K   = 4'd3;
  localparam logic [CODE_W-1:0] SZ_16K  = 4'd4;
  localparam logic [CODE_W-1:0] SZ_32K  = 4'd5;
  localparam logic [CODE_W-1:0] SZ_64K  = 4'd6;
  localparam logic [CODE_W-1:0] SZ_128K = 4'd7;
  localparam logic [CODE_W-1:0] SZ_256K = 4'd8;
  localparam logic [CODE_W-1:0] SZ_512K = 4'd9;
  localparam logic [CODE_W-1:0] SZ_1M   = 4'd10;

  localparam logic [CODE_W-1:0] SIZE_RESET = SZ_2K;
  localparam logic [7:0]        BASE_RESET = 8'hA0;

  typedef enum logic {
    CFG_SIZE_CLASS  = 1'b0,
    CFG_DEVICE_BASE = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic                is_write;
    logic [CODE_W-1:0]   code;
    logic [7:0]          page_mask;
    logic [ADDR_W-1:0]   addr;
    logic [LEN_W-1:0]    len;
  } req_t;

  typedef struct packed {
    logic [7:0]  dev;
    logic [15:0] mem;
    logic        wide;
  } split_t;

  function automatic logic [7:0] page_mask_of(input logic [CODE_W-1:0] code);
    logic [7:0] m;
    begin
      unique case (code)
        SZ_1K, SZ_2K:            m = 8'h07;
        SZ_4K, SZ_8K, SZ_16K:    m = 8'h0f;
        SZ_32K, SZ_64K:          m = 8'h1f;
        SZ_128K, SZ_256K:        m = 8'h3f;
        SZ_512K:                 m = 8'h7f;
        default:                 m = 8'hff;
      endcase
      return m;
    end
  endfunction

  function automatic split_t addr_split(input logic [CODE_W-1:0] code,
                                        input logic [7:0] base,
                                        input logic [ADDR_W-1:0] addr);
    split_t s;
    begin
      s.dev  = base;
      s.mem  = {8'h00, addr[7:0]};
      s.wide = 1'b0;
      unique case (code)
        SZ_1K, SZ_2K: ;
        SZ_4K:  s.dev = base | {6'b0, addr[8], 1'b0};
        SZ_8K:  s.dev = base | {5'b0, addr[9:8], 1'b0};
        SZ_16K: s.dev = base | {4'b0, addr[10:8], 1'b0};
        SZ_1M: begin
          s.dev  = base | {6'b0, addr[16], 1'b0};
          s.mem  = addr[15:0];
          s.wide = 1'b1;
        end
        default: begin
          s.mem  = addr[15:0];
          s.wide = 1'b1;
        end
      endcase
      return s;
    end
  endfunction

endpackage

@@ sv/eeprom_page_write_splitter_top.sv @@
// ----------------------------------------------------------------------------
// eeprom_page_write_splitter_top
// Splits linear 24Cxx EEPROM requests into page-aligned I2C transfer descriptors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_command/in_start_address/in_byte_count and raise
//   in_push; the request transfers on a clock edge with in_full low.
//   Result channel: while out_empty is low the oldest descriptor is on the
//   out_* ports; raise out_pop to take it. out_last marks the final
//   descriptor of a request. A read gives one descriptor; a write gives one
//   per page chunk (one empty chunk for a zero count).
//   Configuration: cfg_index 0 selects the size class, 1 the device base;
//   cfg_ready is always high. Write only while the block is idle.
// Timing:
//   When idle, a request is written into the queue, loaded into the working
//   registers and then registered at the output. The chunk sequencer gives one
//   descriptor per cycle while the output register is empty or popped, after
//   a load step per request (up to 33 chunks for 256 bytes on 8-byte pages).
//   Working out one chunk at a time sets that rate; a two-deep request queue
//   lets new requests transfer while a long write is still being split.
// Reset: rst_n (synchronous, active low) empties the queue and output, and
//   sets size class 1 (2 Kbit) and device base 0xA0.
// Stall: when out_pop stays low the descriptor holds and the sequencer
//   stops; the queue then fills and in_full rises.
// ----------------------------------------------------------------------------
module eeprom_page_write_splitter_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [7:0]                 cfg_data,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic                       in_command,
  input  logic [epws_pkg::ADDR_W-1:0] in_start_address,
  input  logic [epws_pkg::LEN_W-1:0]  in_byte_count,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [7:0]                 out_dev_address,
  output logic [15:0]                out_mem_address,
  output logic                       out_wide_address,
  output logic [epws_pkg::LEN_W-1:0] out_chunk_length,
  output logic                       out_is_write,
  output logic                       out_last
);
  import epws_pkg::*;

  req_t       front_req;
  req_t       q_data;
  logic [7:0] device_base;
  logic       q_valid;
  logic       q_pop;

  // classify the incoming request and hold the configuration
  epws_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_command       (in_command),
    .in_start_address (in_start_address),
    .in_byte_count    (in_byte_count),
    .req              (front_req),
    .device_base      (device_base)
  );

  // decouple intake from chunk sequencing
  epws_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_push),
    .wr_data  (front_req),
    .full     (in_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_data)
  );

  // walk each request page by page
  epws_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_data           (q_data),
    .device_base      (device_base),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_dev_address  (out_dev_address),
    .out_mem_address  (out_mem_address),
    .out_wide_address (out_wide_address),
    .out_chunk_length (out_chunk_length),
    .out_is_write     (out_is_write),
    .out_last         (out_last)
  );

endmodule

@@ sv/epws_front.sv @@
// ----------------------------------------------------------------------------
// epws_front
// Configuration registers and request classification (size code, page, count).
// ----------------------------------------------------------------------------
module epws_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_index,
  input  logic [7:0]              cfg_data,
  input  logic                    in_command,
  input  logic [epws_pkg::ADDR_W-1:0] in_start_address,
  input  logic [epws_pkg::LEN_W-1:0]  in_byte_count,
  output epws_pkg::req_t          req,
  output logic [7:0]              device_base
);
  import epws_pkg::*;

  logic [CODE_W-1:0] size_class_r, size_class_nxt;
  logic [7:0]        device_base_r, device_base_nxt;
  logic [CODE_W-1:0] code;

  assign cfg_ready = 1'b1;

  always_comb begin
    size_class_nxt  = size_class_r;
    device_base_nxt = device_base_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SIZE_CLASS:  size_class_nxt  = cfg_data[CODE_W-1:0];
        CFG_DEVICE_BASE: device_base_nxt = cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_class_r  <= SIZE_RESET;
      device_base_r <= BASE_RESET;
    end else begin
      size_class_r  <= size_class_nxt;
      device_base_r <= device_base_nxt;
    end
  end

  // clamp codes above the largest part
  assign code = (size_class_r > SZ_1M) ? SZ_1M : size_class_r;

  always_comb begin
    req.is_write  = (cmd_t'(in_command) == CMD_WRITE);
    req.code      = code;
    req.page_mask = page_mask_of(code);
    req.addr      = in_start_address;
    req.len       = (in_byte_count > MAX_LEN) ? MAX_LEN : in_byte_count;
  end

  assign device_base = device_base_r;

endmodule

@@ sv/epws_queue.sv @@
// ----------------------------------------------------------------------------
// epws_queue
// Short request queue between classification and chunk sequencing.
// ----------------------------------------------------------------------------
module epws_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  epws_pkg::req_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output logic           rd_valid,
  output epws_pkg::req_t rd_data
);
  import epws_pkg::*;

  req_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_wr, do_rd;

  assign full     = (count_r == (QPTR_W+1)'(QDEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wr_ptr_nxt = do_wr ? ((wr_ptr_r == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? ((rd_ptr_r == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W+1)'(do_wr) - (QPTR_W+1)'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ sv/epws_back.sv @@
// ----------------------------------------------------------------------------
// epws_back
// Chunk sequencer: walks one request page by page into an output register.
// ----------------------------------------------------------------------------
module epws_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  output logic                       q_pop,
  input  epws_pkg::req_t             q_data,
  input  logic [7:0]                 device_base,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [7:0]                 out_dev_address,
  output logic [15:0]                out_mem_address,
  output logic                       out_wide_address,
  output logic [epws_pkg::LEN_W-1:0] out_chunk_length,
  output logic                       out_is_write,
  output logic                       out_last
);
  import epws_pkg::*;

  logic              busy_r, busy_nxt;
  logic              wr_r;
  logic [CODE_W-1:0] code_r;
  logic [7:0]        mask_r;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [7:0]        dev_r;
  logic [15:0]       mem_r;
  logic              wide_r, iswr_r, last_r;
  logic [LEN_W-1:0]  clen_r;

  logic [7:0]        off;
  logic [LEN_W-1:0]  room, w;
  logic              fire, load;
  split_t            sp;

  always_comb begin
    off      = addr_r[7:0] & mask_r;
    room     = {1'b0, mask_r & ~off} + LEN_W'(1);
    w        = (!wr_r || (room > rem_r)) ? rem_r : room;
    rem_nxt  = rem_r - w;
    addr_nxt = addr_r + {{(ADDR_W-LEN_W){1'b0}}, w};
    sp       = addr_split(code_r, device_base, addr_r);
    fire     = busy_r && (!ovalid_r || out_pop);
    load     = q_valid && !busy_r;
  end

  always_comb begin
    busy_nxt = busy_r;
    if (load) begin
      busy_nxt = 1'b1;
    end else if (fire && (rem_nxt == '0)) begin
      busy_nxt = 1'b0;
    end
    ovalid_nxt = ovalid_r;
    if (fire) begin
      ovalid_nxt = 1'b1;
    end else if (out_pop) begin
      ovalid_nxt = 1'b0;
    end
  end

  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // request working registers
  always_ff @(posedge clk) begin
    if (load) begin
      wr_r   <= q_data.is_write;
      code_r <= q_data.code;
      mask_r <= q_data.page_mask;
      addr_r <= q_data.addr;
      rem_r  <= q_data.len;
    end else if (fire) begin
      addr_r <= addr_nxt;
      rem_r  <= rem_nxt;
    end
  end

  // descriptor output register
  always_ff @(posedge clk) begin
    if (fire) begin
      dev_r  <= sp.dev;
      mem_r  <= sp.mem;
      wide_r <= sp.wide;
      clen_r <= w;
      iswr_r <= wr_r;
      last_r <= (rem_nxt == '0);
    end
  end

  assign out_empty        = !ovalid_r;
  assign out_dev_address  = dev_r;
  assign out_mem_address  = mem_r;
  assign out_wide_address = wide_r;
  assign out_chunk_length = clen_r;
  assign out_is_write     = iswr_r;
  assign out_last         = last_r;

endmodule
